[rtl/rtt_pkg.sv]
// Package for the request tag tracker: item structs, request and status codes.
// Used by rtt_store and request_tag_tracker.

package rtt_pkg;

  localparam int TAGS_DEF = 256;
  localparam int TAG_BITS = 16;
  localparam int OP_BITS  = 8;

  localparam logic [2:0] REQ_RESERVE    = 3'd0;
  localparam logic [2:0] REQ_RESPONSE   = 3'd1;
  localparam logic [2:0] REQ_COMPLETION = 3'd2;
  localparam logic [2:0] REQ_ERROR      = 3'd3;
  localparam logic [2:0] REQ_CANCEL     = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNKNOWN = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  typedef struct packed {
    logic [2:0]          req_type;
    logic [OP_BITS-1:0]  op_code;
    logic [TAG_BITS-1:0] tag_in;
    logic                has_values;
  } req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [TAG_BITS-1:0] tag_out;
    logic [OP_BITS-1:0]  stored_op;
  } rsp_t;

  // Control from the sequencer to the tag store.
  typedef struct packed {
    logic occ_we;
    logic occ_wdata;
    logic op_we;
    logic rd_en;
  } store_ctl_t;

endpackage

[rtl/rtt_store.sv]
// Tag store: occupancy bit and opcode per tag, one write and one registered read per cycle.
// Depends on rtt_pkg.

module rtt_store #(
  parameter int TAGS  = rtt_pkg::TAGS_DEF,
  parameter int TAG_W = $clog2(TAGS)
) (
  input  logic                      clk,
  input  rtt_pkg::store_ctl_t       ctl,
  input  logic [TAG_W-1:0]          wr_addr,
  input  logic [rtt_pkg::OP_BITS-1:0] op_wdata,
  input  logic [TAG_W-1:0]          rd_addr,
  output logic                      occ_rdata,
  output logic [rtt_pkg::OP_BITS-1:0] op_rdata
);
  import rtt_pkg::*;

  logic               occ_mem [TAGS];
  logic [OP_BITS-1:0] op_mem  [TAGS];

  always_ff @(posedge clk) begin
    if (ctl.occ_we) begin
      occ_mem[wr_addr] <= ctl.occ_wdata;
    end
    if (ctl.rd_en) begin
      occ_rdata <= occ_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.op_we) begin
      op_mem[wr_addr] <= op_wdata;
    end
    if (ctl.rd_en) begin
      op_rdata <= op_mem[rd_addr];
    end
  end

endmodule

[rtl/request_tag_tracker.sv]
// Request tag tracker top level: sequencer with one probe unit walking the tag store.
// Depends on rtt_pkg and rtt_store.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+--------------------------------
//   req     | in        | req_valid / req_ready | req_type, op_code, tag_in, has_values
//   rsp     | out       | rsp_valid / rsp_ready | status, tag_out, stored_op
//
// After reset the occupancy map is cleared one tag per cycle, with req_ready low until it is done.
// Ignored items and out-of-range tags answer in the cycle after the beat; free items first read the store in S_LOOKUP.
// A reserve probes tags in S_SEARCH, one store read per cycle, up to
// TAGS tags when the table is full. One item is in flight at a time; req_ready needs the result
// register empty or draining, so a stalled rsp holds off the next req beat.

module request_tag_tracker #(
  parameter int TAGS = rtt_pkg::TAGS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  rtt_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output rtt_pkg::rsp_t rsp
);
  import rtt_pkg::*;

  localparam int TAG_W = $clog2(TAGS);
  localparam logic [TAG_W-1:0]    LAST     = TAG_W'(TAGS - 1);
  localparam logic [TAG_BITS:0]   TAGS_EXT = (TAG_BITS + 1)'(TAGS);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SEARCH = 3'd2;
  localparam logic [2:0] S_LOOKUP = 3'd3;

  logic [2:0]          state, state_next;
  logic [TAG_W-1:0]    clr_addr;
  logic [TAG_W-1:0]    last_tag;
  logic [TAG_W-1:0]    probe;
  logic [TAG_W-1:0]    remain;
  logic [OP_BITS-1:0]  op_hold;
  logic [TAG_BITS-1:0] tag_hold;

  store_ctl_t          ctl;
  logic [TAG_W-1:0]    wr_addr, rd_addr;
  logic                occ_rdata;
  logic [OP_BITS-1:0]  op_rdata;

  logic                accept, is_free, in_range;
  logic [TAG_W-1:0]    probe_base, probe_inc;
  logic                finish;
  rsp_t                result;

  assign accept   = req_valid && req_ready;
  assign req_ready = (state == S_IDLE) && (!rsp_valid || rsp_ready);
  assign in_range = {1'b0, req.tag_in} < TAGS_EXT;
  assign is_free  = (req.req_type == REQ_RESPONSE) || (req.req_type == REQ_ERROR) ||
                    (req.req_type == REQ_CANCEL) ||
                    ((req.req_type == REQ_COMPLETION) && !req.has_values);

  // Shared probe unit: next tag with wrap at TAGS.
  assign probe_base = (state == S_SEARCH) ? probe : last_tag;
  assign probe_inc  = (probe_base == LAST) ? '0 : probe_base + 1'b1;

  always_comb begin
    state_next = state;
    ctl        = '0;
    wr_addr    = clr_addr;
    rd_addr    = probe_inc;
    finish     = 1'b0;
    result     = '0;
    unique case (state)
      S_CLEAR: begin
        ctl.occ_we = 1'b1;
        if (clr_addr == LAST) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req.req_type != REQ_RESERVE) begin
          rd_addr = req.tag_in[TAG_W-1:0];
        end
        if (accept) begin
          priority if (req.req_type == REQ_RESERVE) begin
            ctl.rd_en  = 1'b1;
            state_next = S_SEARCH;
          end else if (is_free && in_range) begin
            ctl.rd_en  = 1'b1;
            state_next = S_LOOKUP;
          end else if (is_free) begin
            finish         = 1'b1;
            result.status  = ST_UNKNOWN;
            result.tag_out = req.tag_in;
          end else begin
            finish         = 1'b1;
            result.status  = ST_IGNORED;
            result.tag_out = req.tag_in;
          end
        end
      end
      S_SEARCH: begin
        wr_addr = probe;
        if (!occ_rdata) begin
          ctl.occ_we     = 1'b1;
          ctl.occ_wdata  = 1'b1;
          ctl.op_we      = 1'b1;
          finish         = 1'b1;
          result.status  = ST_OK;
          result.tag_out = TAG_BITS'(probe);
          state_next     = S_IDLE;
        end else if (remain == '0) begin
          finish        = 1'b1;
          result.status = ST_FULL;
          state_next    = S_IDLE;
        end else begin
          ctl.rd_en = 1'b1;
        end
      end
      S_LOOKUP: begin
        wr_addr        = tag_hold[TAG_W-1:0];
        finish         = 1'b1;
        result.tag_out = tag_hold;
        state_next     = S_IDLE;
        if (occ_rdata) begin
          ctl.occ_we       = 1'b1;
          result.status    = ST_OK;
          result.stored_op = op_rdata;
        end else begin
          result.status = ST_UNKNOWN;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      last_tag  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == S_SEARCH && !occ_rdata) begin
        last_tag <= probe;
      end
      if (finish) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (finish) begin
      rsp <= result;
    end
    if (accept) begin
      op_hold  <= req.op_code;
      tag_hold <= req.tag_in;
      probe    <= probe_inc;
      remain   <= LAST;
    end else if (state == S_SEARCH) begin
      probe  <= probe_inc;
      remain <= remain - 1'b1;
    end
  end

  rtt_store #(
    .TAGS  (TAGS),
    .TAG_W (TAG_W)
  ) u_store (
    .clk       (clk),
    .ctl       (ctl),
    .wr_addr   (wr_addr),
    .op_wdata  (op_hold),
    .rd_addr   (rd_addr),
    .occ_rdata (occ_rdata),
    .op_rdata  (op_rdata)
  );

  a_reserve_searches: assert property (@(posedge clk) disable iff (rst)
    (accept && req.req_type == REQ_RESERVE) |=> (state == S_SEARCH))
    else $error("reserve beat did not start a search");

  a_claim_reports_tag: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH && !occ_rdata) |=>
      (rsp_valid && rsp.status == ST_OK && rsp.tag_out == TAG_BITS'(last_tag)))
    else $error("claimed tag not reported or last tag not updated");

  a_search_counts_down: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH && occ_rdata && remain != '0) |=>
      (state == S_SEARCH && remain == $past(remain) - 1'b1))
    else $error("search try count did not advance");

  a_full_is_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == ST_FULL) |-> (rsp.tag_out == '0 && rsp.stored_op == '0))
    else $error("full result carries nonzero fields");

  a_no_beat_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |=> !(finish && $past(state) == S_CLEAR && state == S_IDLE && rsp_valid))
    else $error("result produced during clearing pass");

endmodule

[bench/request_tag_tracker_tb.sv]
// Self-checking bench for request_tag_tracker: round-robin reserve, free by tag, full table.
// Depends on rtt_pkg and the request_tag_tracker RTL; a tag-table predictor checks every beat.

module request_tag_tracker_tb;
  import rtt_pkg::*;

  localparam int TAGS_N         = TAGS_DEF;
  localparam int ITEM_TARGET    = 1950;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  request_tag_tracker #(.TAGS(TAGS_N)) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  // Predicted tag table
  bit         tag_busy [TAGS_N];
  bit   [7:0] tag_op   [TAGS_N];
  int         last_claim;
  int         tags_held;

  req_t req_pending [$];
  rsp_t rsp_expected [$];

  int  items_made;
  int  items_taken;
  int  mismatch_cnt;
  int  send_wait;
  int  take_wait;
  int  take_draw;
  int  idle_cycles;
  int  churn_pick;
  bit  quiet_send;
  bit  quiet_take;
  rsp_t want;

  function automatic int draw_wait(bit quiet);
    return quiet ? 0 : $urandom_range(0, 4);
  endfunction

  function automatic rsp_t tracker_release(req_t r);
    rsp_t o;
    o = '0;
    o.tag_out = r.tag_in;
    if (r.tag_in < TAGS_N && tag_busy[r.tag_in]) begin
      tag_busy[r.tag_in] = 1'b0;
      tags_held--;
      o.status = ST_OK;
      o.stored_op = tag_op[r.tag_in];
    end else begin
      o.status = ST_UNKNOWN;
    end
    return o;
  endfunction

  function automatic rsp_t tracker_apply(req_t r);
    rsp_t o;
    int probe;
    o = '0;
    case (r.req_type)
      REQ_RESERVE: begin
        o.status = ST_FULL;
        probe = last_claim;
        for (int i = 0; i < TAGS_N; i++) begin
          probe = (probe + 1) % TAGS_N;
          if (!tag_busy[probe]) begin
            tag_busy[probe] = 1'b1;
            tag_op[probe] = r.op_code;
            last_claim = probe;
            tags_held++;
            o.status = ST_OK;
            o.tag_out = TAG_BITS'(probe);
            break;
          end
        end
      end
      REQ_RESPONSE, REQ_ERROR, REQ_CANCEL: o = tracker_release(r);
      REQ_COMPLETION: begin
        if (!r.has_values) begin
          o = tracker_release(r);
        end else begin
          o.status = ST_IGNORED;
          o.tag_out = r.tag_in;
        end
      end
      default: begin
        o.status = ST_IGNORED;
        o.tag_out = r.tag_in;
      end
    endcase
    return o;
  endfunction

  task automatic report_error(string msg);
    $display("request_tag_tracker_tb: %s at %0t", msg, $realtime);
    mismatch_cnt++;
  endtask

  task automatic queue_req(logic [2:0] kind, logic [7:0] op, logic [15:0] tag, logic hv);
    req_t r;
    r.req_type = kind;
    r.op_code = op;
    r.tag_in = tag;
    r.has_values = hv;
    req_pending.push_back(r);
    items_made++;
  endtask

  // Pick a tag the table holds right now; falls back to a free one if none is held.
  function automatic logic [15:0] held_tag_pick();
    int start;
    int t;
    start = $urandom_range(0, TAGS_N - 1);
    for (int i = 0; i < TAGS_N; i++) begin
      t = (start + i) % TAGS_N;
      if (tag_busy[t]) return 16'(t);
    end
    return 16'(start);
  endfunction

  task automatic queue_reserve();
    queue_req(REQ_RESERVE, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 16'hffff)),
              1'($urandom_range(0, 1)));
  endtask

  task automatic queue_free();
    logic [2:0] kind;
    case ($urandom_range(0, 3))
      0: kind = REQ_RESPONSE;
      1: kind = REQ_ERROR;
      2: kind = REQ_CANCEL;
      default: kind = REQ_COMPLETION;
    endcase
    queue_req(kind, 8'($urandom_range(0, 255)), held_tag_pick(),
              kind == REQ_COMPLETION ? ($urandom_range(0, 4) == 0) :
                                       1'($urandom_range(0, 1)));
  endtask

  task automatic queue_noise();
    logic [15:0] tag;
    case ($urandom_range(0, 3))
      0: tag = 16'($urandom_range(0, 16'hffff));
      1: tag = 16'(TAGS_N - 2 + $urandom_range(0, 3));
      2: tag = 16'($urandom_range(0, TAGS_N - 1));
      default: tag = 16'hffff - 16'($urandom_range(0, 3));
    endcase
    queue_req(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), tag,
              1'($urandom_range(0, 1)));
  endtask

  // Hold generation until the driver has room, so picks see near-current table state.
  task automatic wait_room();
    while (req_pending.size() > 0) @(posedge clk);
    if (items_made % 128 == 0) begin
      quiet_send = ($urandom_range(0, 3) == 0);
      quiet_take = ($urandom_range(0, 3) == 0);
    end
  endtask

  // Driver: one beat per pending item, random gap after each.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      req <= '0;
      send_wait <= 0;
    end else if (!(req_valid && !req_ready)) begin
      if (req_valid) begin
        rsp_expected.push_back(tracker_apply(req));
        items_taken++;
      end
      if (send_wait != 0) begin
        send_wait <= send_wait - 1;
        req_valid <= 1'b0;
      end else if (req_pending.size() > 0) begin
        req <= req_pending.pop_front();
        req_valid <= 1'b1;
        send_wait <= draw_wait(quiet_send);
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each result beat, then stall a random number of cycles.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      take_wait <= 1;
    end else if (rsp_valid && rsp_ready) begin
      if (rsp_expected.size() == 0) begin
        report_error($sformatf("unexpected result status %0d tag %0h op %0h",
                               rsp.status, rsp.tag_out, rsp.stored_op));
      end else begin
        want = rsp_expected.pop_front();
        if (rsp.status !== want.status)
          report_error($sformatf("status got %0d want %0d", rsp.status, want.status));
        if (rsp.tag_out !== want.tag_out)
          report_error($sformatf("tag_out got %0h want %0h", rsp.tag_out, want.tag_out));
        if (rsp.stored_op !== want.stored_op)
          report_error($sformatf("stored_op got %0h want %0h", rsp.stored_op, want.stored_op));
      end
      take_draw = draw_wait(quiet_take);
      take_wait <= take_draw;
      rsp_ready <= (take_draw == 0);
    end else if (take_wait != 0) begin
      take_wait <= take_wait - 1;
      rsp_ready <= (take_wait == 1);
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("request_tag_tracker_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    items_made = 0;
    quiet_send = 1'b0;
    quiet_take = 1'b0;

    // Directed: extreme opcodes, every request kind, unknown and out-of-range tags
    queue_req(REQ_RESERVE, 8'h00, 16'h0000, 1'b0);
    queue_req(REQ_RESERVE, 8'hff, 16'hffff, 1'b1);
    queue_req(REQ_RESERVE, 8'h5a, 16'h00a5, 1'b0);
    queue_req(REQ_RESPONSE, 8'hff, 16'd1, 1'b1);
    queue_req(REQ_RESPONSE, 8'h00, 16'd1, 1'b0);
    queue_req(REQ_ERROR, 8'h00, 16'd2, 1'b0);
    queue_req(REQ_CANCEL, 8'h00, 16'd3, 1'b1);
    queue_req(REQ_CANCEL, 8'h00, 16'd0, 1'b0);
    queue_req(REQ_RESERVE, 8'ha5, 16'h0000, 1'b0);
    queue_req(REQ_RESPONSE, 8'h00, 16'(TAGS_N), 1'b0);
    queue_req(REQ_ERROR, 8'h00, 16'hffff, 1'b0);
    queue_req(REQ_COMPLETION, 8'h00, 16'd4, 1'b1);
    queue_req(REQ_COMPLETION, 8'h00, 16'd4, 1'b0);
    queue_req(REQ_COMPLETION, 8'h00, 16'd4, 1'b0);
    queue_req(REQ_COMPLETION, 8'hff, 16'hffff, 1'b1);
    queue_req(3'd5, 8'hff, 16'hffff, 1'b1);
    queue_req(3'd6, 8'h00, 16'd5, 1'b0);
    queue_req(3'd7, 8'h81, 16'h8000, 1'b1);
    queue_req(REQ_RESERVE, 8'h3c, 16'h0000, 1'b0);
    queue_req(REQ_CANCEL, 8'h00, 16'(TAGS_N - 1), 1'b0);
    queue_req(REQ_CANCEL, 8'h00, 16'd5, 1'b0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (items_made < ITEM_TARGET) begin
      // Churn: mostly reserve and free of held tags, some noise
      repeat (100) begin
        wait_room();
        churn_pick = $urandom_range(0, 99);
        if (churn_pick < 50) queue_reserve();
        else if (churn_pick < 88) queue_free();
        else queue_noise();
      end
      // Fill the table, run into full, trade a few tags while crowded
      while (tags_held < TAGS_N) begin
        wait_room();
        if ($urandom_range(0, 19) == 0) queue_noise();
        else queue_reserve();
      end
      repeat (24) begin
        wait_room();
        if ($urandom_range(0, 2) == 0) queue_free();
        else queue_reserve();
      end
      // Drain most of it again
      while (tags_held > 4) begin
        wait_room();
        if ($urandom_range(0, 9) == 0) queue_noise();
        else queue_free();
      end
    end

    while (items_taken != items_made || rsp_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && rsp_expected.size() == 0) begin
      $display("request_tag_tracker_tb: PASS");
    end else begin
      $display("request_tag_tracker_tb: FAIL");
    end
    $finish;
  end

endmodule
